>>> design/idp_pkg.sv
// Shared constants, character codes and the power-of-ten table for the ISO duration parser.
package idp_pkg;

	localparam int CHAR_BITS  = 8;
	localparam int TOTAL_BITS = 48;
	localparam int MUL_BITS   = 17;
	localparam int QHI_BITS   = 18;
	localparam int USER_BITS  = 2;
	localparam int USER_ERR   = 0;
	localparam int USER_SAT   = 1;

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	localparam logic [CHAR_BITS-1:0] CH_P   = 8'h50;
	localparam logic [CHAR_BITS-1:0] CH_T   = 8'h54;
	localparam logic [CHAR_BITS-1:0] CH_D   = 8'h44;
	localparam logic [CHAR_BITS-1:0] CH_H   = 8'h48;
	localparam logic [CHAR_BITS-1:0] CH_M   = 8'h4D;
	localparam logic [CHAR_BITS-1:0] CH_S   = 8'h53;
	localparam logic [CHAR_BITS-1:0] CH_DOT = 8'h2E;
	localparam logic [CHAR_BITS-1:0] CH_0   = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_9   = 8'h39;

	localparam logic [MUL_BITS-1:0] MUL_DAY  = 17'd86400;
	localparam logic [MUL_BITS-1:0] MUL_HOUR = 17'd3600;
	localparam logic [MUL_BITS-1:0] MUL_MIN  = 17'd60;
	localparam logic [MUL_BITS-1:0] MUL_SEC  = 17'd1;
	localparam logic [MUL_BITS-1:0] MUL_NONE = 17'd0;

	function automatic logic [29:0] pow10(input logic [3:0] n);
		logic [29:0] v;
		case (n)
			4'd0:    v = 30'd1;
			4'd1:    v = 30'd10;
			4'd2:    v = 30'd100;
			4'd3:    v = 30'd1000;
			4'd4:    v = 30'd10000;
			4'd5:    v = 30'd100000;
			4'd6:    v = 30'd1000000;
			4'd7:    v = 30'd10000000;
			4'd8:    v = 30'd100000000;
			4'd9:    v = 30'd1000000000;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

>>> design/iso_duration_parser_top.sv
// ISO 8601 duration parser: character stream in, total whole seconds out.
//
//  channel | dir | payload                                   | accept
//  s_*     | in  | tdata: char_code[7:0]; tlast: last        | s_tvalid & s_tready
//  m_*     | out | tdata: seconds[47:0]; tuser: error, satur. | m_tvalid & m_tready
//
// One character is taken per cycle while s_tready is high. The result of a string
// shows on m_tvalid once its last character has passed the six-stage chain that
// scales the whole part and the fraction (input capture, multiply, reciprocal
// estimate, back-multiply, correction, unit add) ahead of the running total.
// Reset clears the run state, the stage valid bits, the running total and m_tvalid.
// Only the last stage, when it holds a last character, waits on the output register;
// earlier stages stall behind it only when full, so bubbles collapse while a result is pending.
module iso_duration_parser_top #(
	parameter int FRAC_DIGITS = 6,
	parameter int WHOLE_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [idp_pkg::CHAR_BITS-1:0] s_tdata,   // char_code[7:0]
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [idp_pkg::TOTAL_BITS-1:0] m_tdata,  // seconds[47:0]
	output logic [idp_pkg::USER_BITS-1:0] m_tuser    // [0] error, [1] saturated
);
	import idp_pkg::*;

	localparam longint unsigned FRAC_SCALE = longint'(pow10(4'(FRAC_DIGITS)));
	localparam int FB    = $clog2(FRAC_SCALE);
	localparam int CB    = $clog2(FRAC_DIGITS + 1);
	localparam int WB    = WHOLE_BITS;
	localparam int PB    = FB + MUL_BITS;
	localparam int PWB   = WB + MUL_BITS;
	localparam int AB    = PWB + 1;
	localparam int SB    = ((AB > TOTAL_BITS) ? AB : TOTAL_BITS) + 1;
	localparam int SHIFT = $clog2(FRAC_SCALE + 1) - 1;
	localparam int RW    = QHI_BITS + 1;
	localparam longint unsigned RCP_VAL = (64'd1 << (SHIFT + QHI_BITS)) / FRAC_SCALE;

	localparam logic [RW-1:0] RCP       = RW'(RCP_VAL);
	localparam logic [PB-1:0] SCALE_X1  = PB'(FRAC_SCALE);
	localparam logic [PB-1:0] SCALE_X2  = PB'(2 * FRAC_SCALE);
	localparam logic [CB-1:0] FRAC_LIM  = CB'(FRAC_DIGITS);

	// run state
	logic          started_q, bad_q, time_q, point_q, digit_q;
	logic [WB-1:0] whole_q;
	logic [FB-1:0] frac_q;
	logic [CB-1:0] frac_cnt_q;

	logic          started_n, bad_n, time_n, point_n, digit_n;
	logic [WB-1:0] whole_n;
	logic [FB-1:0] frac_n;
	logic [CB-1:0] frac_cnt_n;
	logic [MUL_BITS-1:0] fe_mul;
	logic          fe_ev;

	logic [WB+3:0] whole_ext;
	logic [3:0]    place_idx;
	logic [3:0]    digit;

	// stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	logic in_fire, consume, out_free;

	logic [MUL_BITS-1:0] mul_s1;
	logic [WB-1:0]       whole_s1;
	logic [FB-1:0]       frac_s1;
	logic ev_s1, last_s1, err_s1;

	logic [PWB-1:0] prodw_s2, prodw_s3, prodw_s4, prodw_s5;
	logic [PB-1:0]  fprod_s2, fprod_s3, fprod_s4;
	logic ev_s2, last_s2, err_s2;
	logic ev_s3, last_s3, err_s3;
	logic ev_s4, last_s4, err_s4;
	logic ev_s5, last_s5, err_s5;
	logic ev_s6, last_s6, err_s6;

	logic [QHI_BITS-1:0]    p_hi;
	logic [QHI_BITS+RW-1:0] qe_prod;
	logic [MUL_BITS-1:0]    qe_s3, qe_s4, q_s5;
	logic [PB-1:0]          qd_s4;
	logic [PB-1:0]          rem;
	logic [AB-1:0]          add_s6;

	logic [SB-1:0]         sum;
	logic                  over;
	logic [TOTAL_BITS-1:0] sum_sat;

	logic [TOTAL_BITS-1:0] total_q;
	logic                  clamp_q;
	logic                  out_valid_q;
	logic [TOTAL_BITS-1:0] seconds_q;
	logic                  err_q, sat_q;

	assign digit     = s_tdata[3:0];
	assign place_idx = 4'(FRAC_DIGITS - 1) - 4'(frac_cnt_q);
	assign whole_ext = (WB+4)'(whole_q) * (WB+4)'(10) + (WB+4)'(digit);

	always_comb begin
		started_n  = started_q;
		bad_n      = bad_q;
		time_n     = time_q;
		point_n    = point_q;
		digit_n    = digit_q;
		whole_n    = whole_q;
		frac_n     = frac_q;
		frac_cnt_n = frac_cnt_q;
		fe_mul     = MUL_NONE;
		fe_ev      = 1'b0;
		if (!started_q) begin
			started_n = 1'b1;
			bad_n     = (s_tdata != CH_P);
		end else if (!bad_q) begin
			if (s_tdata inside {[CH_0:CH_9]}) begin
				digit_n = 1'b1;
				if (!point_q) begin
					if (whole_ext[WB+3:WB] != 4'd0) begin
						whole_n = {WB{1'b1}};
						fe_ev   = 1'b1;
					end else begin
						whole_n = whole_ext[WB-1:0];
					end
				end else if (frac_cnt_q < FRAC_LIM) begin
					frac_n     = FB'(34'(frac_q) + 34'(digit) * 34'(pow10(place_idx)));
					frac_cnt_n = frac_cnt_q + CB'(1);
				end
			end else if (s_tdata == CH_DOT && !point_q) begin
				point_n = 1'b1;
			end else if (s_tdata == CH_DOT && !digit_q) begin
				// lone point repeated: hold
			end else begin
				case (s_tdata)
					CH_D:    fe_mul = MUL_DAY;
					CH_H:    fe_mul = MUL_HOUR;
					CH_S:    fe_mul = MUL_SEC;
					CH_M:    fe_mul = time_q ? MUL_MIN : MUL_NONE;
					CH_T:    time_n = 1'b1;
					default: fe_mul = MUL_NONE;
				endcase
				whole_n    = '0;
				frac_n     = '0;
				frac_cnt_n = '0;
				point_n    = 1'b0;
				digit_n    = 1'b0;
			end
		end
	end

	// ready chain: a stage moves if empty or its successor moves; stage 6 stalls only on a last char
	assign out_free = !out_valid_q || m_tready;
	assign rdy6     = !v_s6 || !last_s6 || out_free;
	assign rdy5     = !v_s5 || rdy6;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;
	assign in_fire  = s_tvalid && rdy1;
	assign consume  = v_s6 && rdy6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			bad_q      <= 1'b0;
			time_q     <= 1'b0;
			point_q    <= 1'b0;
			digit_q    <= 1'b0;
			whole_q    <= '0;
			frac_q     <= '0;
			frac_cnt_q <= '0;
		end else if (in_fire) begin
			if (s_tlast) begin
				started_q  <= 1'b0;
				bad_q      <= 1'b0;
				time_q     <= 1'b0;
				point_q    <= 1'b0;
				digit_q    <= 1'b0;
				whole_q    <= '0;
				frac_q     <= '0;
				frac_cnt_q <= '0;
			end else begin
				started_q  <= started_n;
				bad_q      <= bad_n;
				time_q     <= time_n;
				point_q    <= point_n;
				digit_q    <= digit_n;
				whole_q    <= whole_n;
				frac_q     <= frac_n;
				frac_cnt_q <= frac_cnt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	assign p_hi    = QHI_BITS'(fprod_s2 >> SHIFT);
	assign qe_prod = (QHI_BITS+RW)'(p_hi) * (QHI_BITS+RW)'(RCP);
	assign rem     = fprod_s4 - qd_s4;

	// payload: the pending number rides along with its unit multiplier
	always_ff @(posedge clk) begin
		if (rdy1) begin
			mul_s1   <= fe_mul;
			whole_s1 <= whole_q;
			frac_s1  <= frac_q;
			ev_s1    <= fe_ev;
			last_s1  <= s_tlast;
			err_s1   <= bad_n;
		end
		if (rdy2) begin
			prodw_s2 <= PWB'(whole_s1) * PWB'(mul_s1);
			fprod_s2 <= PB'(frac_s1) * PB'(mul_s1);
			ev_s2    <= ev_s1;
			last_s2  <= last_s1;
			err_s2   <= err_s1;
		end
		if (rdy3) begin
			// quotient estimate, low by at most two
			qe_s3    <= MUL_BITS'(qe_prod >> QHI_BITS);
			fprod_s3 <= fprod_s2;
			prodw_s3 <= prodw_s2;
			ev_s3    <= ev_s2;
			last_s3  <= last_s2;
			err_s3   <= err_s2;
		end
		if (rdy4) begin
			qd_s4    <= PB'(PB'(qe_s3) * SCALE_X1);
			qe_s4    <= qe_s3;
			fprod_s4 <= fprod_s3;
			prodw_s4 <= prodw_s3;
			ev_s4    <= ev_s3;
			last_s4  <= last_s3;
			err_s4   <= err_s3;
		end
		if (rdy5) begin
			q_s5     <= qe_s4 + MUL_BITS'(rem >= SCALE_X1) + MUL_BITS'(rem >= SCALE_X2);
			prodw_s5 <= prodw_s4;
			ev_s5    <= ev_s4;
			last_s5  <= last_s4;
			err_s5   <= err_s4;
		end
		if (rdy6) begin
			add_s6  <= AB'(prodw_s5) + AB'(q_s5);
			ev_s6   <= ev_s5;
			last_s6 <= last_s5;
			err_s6  <= err_s5;
		end
	end

	assign sum     = SB'(total_q) + SB'(add_s6);
	assign over    = (sum > SB'(TOTAL_MAX));
	assign sum_sat = over ? TOTAL_MAX : sum[TOTAL_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			clamp_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (consume) begin
				if (last_s6) begin
					total_q <= '0;
					clamp_q <= 1'b0;
				end else begin
					total_q <= sum_sat;
					clamp_q <= clamp_q | over | ev_s6;
				end
			end
			if (consume && last_s6) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s6) begin
			seconds_q <= err_s6 ? '0 : sum_sat;
			err_q     <= err_s6;
			sat_q     <= !err_s6 && (clamp_q | over | ev_s6);
		end
	end

	assign m_tvalid           = out_valid_q;
	assign m_tdata            = seconds_q;
	assign m_tuser[USER_ERR]  = err_q;
	assign m_tuser[USER_SAT]  = sat_q;

endmodule

>>> design/idp_checker.sv
// Port-level checks for the ISO duration parser, bound to its top level.
module idp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tlast,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [idp_pkg::TOTAL_BITS-1:0] m_tdata,
	input logic [idp_pkg::USER_BITS-1:0]  m_tuser
);
	import idp_pkg::*;

	logic [3:0] pend_q;
	logic       in_last, out_fire;

	assign in_last  = s_tvalid && s_tready && s_tlast;
	assign out_fire = m_tvalid && m_tready;

	// count strings whose last character went in but whose result is not yet out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_last && !out_fire) begin
			pend_q <= pend_q + 4'd1;
		end else if (!in_last && out_fire) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_ERR] |-> m_tdata == '0 && !m_tuser[USER_SAT])
		else $error("error result carries seconds or saturation");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 4'd0)
		else $error("result without a terminated string");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_last && pend_q == 4'd0 && !m_tvalid |=> !m_tvalid)
		else $error("result appeared one cycle after its last character");

endmodule

bind iso_duration_parser_top idp_checker u_idp_checker (.*);
